// File: rtl/core/sst_pkg.sv
package sst_pkg;

  localparam int PID_W = 15;
  localparam int PAGE_W = 20;
  localparam int SLOT_W = 6;
  localparam int COUNT_W = 7;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_FREE_ALL = 2'd2;
  localparam logic [1:0] ACT_DUP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_SKIP = 2'd3;

  typedef enum logic [2:0] {
    CMD_ALLOC    = 3'd0,
    CMD_LOOKUP   = 3'd1,
    CMD_FREE_ALL = 3'd2,
    CMD_DUP      = 3'd3,
    CMD_SKIP     = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic [PID_W-1:0] pid;
    logic [PAGE_W-1:0] page;
    logic [PID_W-1:0] new_pid;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] source_slot;
    logic [COUNT_W-1:0] freed_count;
    logic last;
  } res_t;

  typedef struct packed {
    logic used;
    logic [PID_W-1:0] owner;
    logic [PAGE_W-1:0] page;
  } entry_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } be_ctl_t;

endpackage

// File: rtl/core/sst_fifo.sv
module sst_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = PW + 1;

  logic [W-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/sst_front.sv
module sst_front import sst_pkg::*; #(
  parameter int CMD_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        action,
  input  logic [PID_W-1:0]  pid,
  input  logic [PAGE_W-1:0] page_number,
  input  logic              in_segment,
  input  logic [PID_W-1:0]  new_pid,
  input  be_ctl_t           ctl,
  output logic              cmd_valid,
  output cmd_t              cmd
);

  cmd_t cmd_in;
  logic q_full;
  logic q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    cmd_in.pid = pid;
    cmd_in.page = page_number;
    cmd_in.new_pid = new_pid;
    case (action)
      ACT_ALLOC: cmd_in.op = in_segment ? CMD_SKIP : CMD_ALLOC;
      ACT_LOOKUP: cmd_in.op = CMD_LOOKUP;
      ACT_FREE_ALL: cmd_in.op = CMD_FREE_ALL;
      ACT_DUP: cmd_in.op = CMD_DUP;
      default: cmd_in.op = CMD_SKIP;
    endcase
  end

  // No request is taken while the slot table is being cleared.
  assign full = q_full || ctl.clearing;
  assign cmd_valid = !q_empty;
  assign cmd = cmd_t'(q_rdata);

  sst_fifo #(
    .W($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk(clk),
    .rst(rst),
    .push(push && !ctl.clearing),
    .wdata(cmd_in),
    .full(q_full),
    .pop(ctl.pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

endmodule

// File: rtl/core/sst_back.sv
module sst_back import sst_pkg::*; #(
  parameter int SLOTS = 64,
  parameter int RES_DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output be_ctl_t ctl,
  output res_t    res,
  output logic    res_empty,
  input  logic    res_pop
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOT_END = CW'(SLOTS);

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_RD      = 14'b00000000000100,
    S_EV      = 14'b00000000001000,
    S_MK_RD   = 14'b00000000010000,
    S_MK_EV   = 14'b00000000100000,
    S_MS_RD   = 14'b00000001000000,
    S_MS_EV   = 14'b00000010000000,
    S_SRC_RD  = 14'b00000100000000,
    S_SRC_EV  = 14'b00001000000000,
    S_FREE_RD = 14'b00010000000000,
    S_FREE_EV = 14'b00100000000000,
    S_FLUSH   = 14'b01000000000000,
    S_SPARE   = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  cmd_t cur, cur_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] s, s_next;
  logic [CW-1:0] f, f_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] cnt_sum;
  logic pend_valid, pend_valid_next;
  res_t pend, pend_next;
  logic [PAGE_W-1:0] src_page, src_page_next;

  entry_t entry_mem [SLOTS];
  logic mark_mem [SLOTS];
  entry_t rd_entry;
  logic rd_mark;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic we;
  entry_t wdata;
  logic mark_we;

  logic owner_match;
  logic page_match;
  logic idx_last;
  logic s_last;
  logic f_over;
  logic f_full;
  logic f_hit;

  logic emit;
  logic emit_last;
  logic res_full;
  res_t res_in;
  logic [$bits(res_t)-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      entry_mem[waddr] <= wdata;
    end
    rd_entry <= entry_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[waddr] <= owner_match;
    end
    rd_mark <= mark_mem[raddr];
  end

  assign owner_match = rd_entry.used && (rd_entry.owner == cur.pid);
  assign page_match = owner_match && (rd_entry.page == cur.page);
  assign idx_last = (idx == LAST_IDX);
  assign s_last = (s == LAST_IDX);
  assign f_over = (f == SLOT_END);
  assign f_full = f_over || (rd_entry.used && (f == LAST_IDX));
  assign f_hit = !f_over && !rd_entry.used;
  assign cnt_sum = cnt + CW'(owner_match);

  always_comb begin
    state_next = state;
    cur_next = cur;
    idx_next = idx;
    s_next = s;
    f_next = f;
    cnt_next = cnt;
    pend_valid_next = pend_valid;
    pend_next = pend;
    src_page_next = src_page;
    raddr = idx[IW-1:0];
    waddr = idx[IW-1:0];
    we = 1'b0;
    wdata = rd_entry;
    mark_we = 1'b0;
    emit = 1'b0;
    emit_last = 1'b0;
    ctl.pop = 1'b0;
    ctl.clearing = 1'b0;

    case (state)
      S_CLEAR: begin
        ctl.clearing = 1'b1;
        we = 1'b1;
        wdata = '0;
        if (idx_last) begin
          idx_next = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.pop = 1'b1;
          cur_next = cmd;
          idx_next = '0;
          cnt_next = '0;
          pend_valid_next = 1'b0;
          case (cmd.op)
            CMD_SKIP: begin
              pend_next = '0;
              pend_next.status = ST_SKIP;
              pend_valid_next = 1'b1;
              state_next = S_FLUSH;
            end
            CMD_DUP: state_next = S_MK_RD;
            default: state_next = S_RD;
          endcase
        end
      end
      S_RD: begin
        state_next = S_EV;
      end
      S_EV: begin
        pend_next = '0;
        case (cur.op)
          CMD_ALLOC: begin
            if (!rd_entry.used) begin
              we = 1'b1;
              wdata.used = 1'b1;
              wdata.owner = cur.pid;
              wdata.page = cur.page;
              pend_next.status = ST_OK;
              pend_next.slot = SLOT_W'(idx);
              pend_valid_next = 1'b1;
              state_next = S_FLUSH;
            end else if (idx_last) begin
              pend_next.status = ST_FULL;
              pend_valid_next = 1'b1;
              state_next = S_FLUSH;
            end else begin
              idx_next = idx + CW'(1);
              state_next = S_RD;
            end
          end
          CMD_LOOKUP: begin
            if (page_match) begin
              we = 1'b1;
              wdata.used = 1'b0;
              pend_next.status = ST_OK;
              pend_next.slot = SLOT_W'(idx);
              pend_valid_next = 1'b1;
              state_next = S_FLUSH;
            end else if (idx_last) begin
              pend_next.status = ST_NONE;
              pend_valid_next = 1'b1;
              state_next = S_FLUSH;
            end else begin
              idx_next = idx + CW'(1);
              state_next = S_RD;
            end
          end
          CMD_FREE_ALL: begin
            if (owner_match) begin
              we = 1'b1;
              wdata.used = 1'b0;
            end
            if (idx_last) begin
              pend_next.status = ST_OK;
              pend_next.freed_count = COUNT_W'(cnt_sum);
              pend_valid_next = 1'b1;
              state_next = S_FLUSH;
            end else begin
              cnt_next = cnt_sum;
              idx_next = idx + CW'(1);
              state_next = S_RD;
            end
          end
          default: begin
            pend_next = pend;
            state_next = S_IDLE;
          end
        endcase
      end
      S_MK_RD: begin
        state_next = S_MK_EV;
      end
      S_MK_EV: begin
        // The source set is frozen here so that new copies are never copied again.
        mark_we = 1'b1;
        if (idx_last) begin
          s_next = '0;
          f_next = '0;
          state_next = S_MS_RD;
        end else begin
          idx_next = idx + CW'(1);
          state_next = S_MK_RD;
        end
      end
      S_MS_RD: begin
        raddr = s[IW-1:0];
        state_next = S_MS_EV;
      end
      S_MS_EV: begin
        raddr = s[IW-1:0];
        if (rd_mark) begin
          state_next = S_SRC_RD;
        end else if (s_last) begin
          if (!pend_valid) begin
            pend_next = '0;
            pend_next.status = ST_NONE;
            pend_valid_next = 1'b1;
          end
          state_next = S_FLUSH;
        end else begin
          s_next = s + CW'(1);
          state_next = S_MS_RD;
        end
      end
      S_SRC_RD: begin
        raddr = s[IW-1:0];
        state_next = S_SRC_EV;
      end
      S_SRC_EV: begin
        raddr = s[IW-1:0];
        src_page_next = rd_entry.page;
        state_next = S_FREE_RD;
      end
      S_FREE_RD: begin
        raddr = f[IW-1:0];
        state_next = S_FREE_EV;
      end
      S_FREE_EV: begin
        raddr = f[IW-1:0];
        waddr = f[IW-1:0];
        if (f_full || f_hit) begin
          if (!(pend_valid && res_full)) begin
            emit = pend_valid;
            pend_next = '0;
            pend_next.source_slot = SLOT_W'(s);
            pend_valid_next = 1'b1;
            if (f_full) begin
              pend_next.status = ST_FULL;
              state_next = S_FLUSH;
            end else begin
              we = 1'b1;
              wdata.used = 1'b1;
              wdata.owner = cur.new_pid;
              wdata.page = src_page;
              pend_next.status = ST_OK;
              pend_next.slot = SLOT_W'(f);
              f_next = f + CW'(1);
              if (s_last) begin
                state_next = S_FLUSH;
              end else begin
                s_next = s + CW'(1);
                state_next = S_MS_RD;
              end
            end
          end
        end else begin
          f_next = f + CW'(1);
          state_next = S_FREE_RD;
        end
      end
      S_FLUSH: begin
        if (!res_full) begin
          emit = 1'b1;
          emit_last = 1'b1;
          pend_valid_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_in = pend;
    res_in.last = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    s <= s_next;
    f <= f_next;
    cnt <= cnt_next;
    pend <= pend_next;
    src_page <= src_page_next;
  end

  sst_fifo #(
    .W($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk(clk),
    .rst(rst),
    .push(emit),
    .wdata(res_in),
    .full(res_full),
    .pop(res_pop),
    .rdata(res_rdata),
    .empty(res_empty)
  );

  assign res = res_t'(res_rdata);

endmodule

// File: rtl/core/swap_slot_table_unit.sv
// Channel   Direction  Handshake                Payload
// request   in         push / full              action pid page_number in_segment new_pid
// result    out        empty / pop              status slot source_slot freed_count last
//
// Every slot probe is a registered table read followed by a step that acts on it.
// Allocate and lookup probe the slots in order up to the hit.
// Free-all probes every slot. Duplicate first runs the source marking pass over every slot,
// then scans the marked source slots, copying each into the next free slot and skipping occupied ones.
// After reset the table is cleared one slot per cycle with full held high.
// Requests queue in front and results queue behind the sequencer, so either side may stall.
module swap_slot_table_unit import sst_pkg::*; #(
  parameter int SLOTS = 64,
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic [PID_W-1:0]   pid,
  input  logic [PAGE_W-1:0]  page_number,
  input  logic               in_segment,
  input  logic [PID_W-1:0]   new_pid,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic [SLOT_W-1:0]  slot,
  output logic [SLOT_W-1:0]  source_slot,
  output logic [COUNT_W-1:0] freed_count,
  output logic               last
);

  be_ctl_t be_ctl;
  logic cmd_valid;
  cmd_t cmd;
  res_t res;

  sst_front #(
    .CMD_DEPTH(CMD_DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .pid(pid),
    .page_number(page_number),
    .in_segment(in_segment),
    .new_pid(new_pid),
    .ctl(be_ctl),
    .cmd_valid(cmd_valid),
    .cmd(cmd)
  );

  sst_back #(
    .SLOTS(SLOTS),
    .RES_DEPTH(RES_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .ctl(be_ctl),
    .res(res),
    .res_empty(empty),
    .res_pop(pop)
  );

  assign status = res.status;
  assign slot = res.slot;
  assign source_slot = res.source_slot;
  assign freed_count = res.freed_count;
  assign last = res.last;

  a_clear_blocks_requests: assert property (@(posedge clk) disable iff (rst)
    be_ctl.clearing |-> full)
    else $error("request accepted while the table is being cleared");

  a_clear_no_results: assert property (@(posedge clk) disable iff (rst)
    be_ctl.clearing |-> empty)
    else $error("result pending during the clearing pass");

  a_count_only_final_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && freed_count != '0) |-> (status == ST_OK && last))
    else $error("freed count on a result that is not a final success");

  a_skip_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_SKIP) |-> (last && slot == '0 && source_slot == '0))
    else $error("skipped allocation result is malformed");

  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_FULL) |-> (last && slot == '0))
    else $error("table-full result carries a slot or is not final");

endmodule
